// ===== hdl/rtcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Remote touch command parser package
// Shared widths, limits, frame bytes, event codes and the result record.
// ----------------------------------------------------------------------------
package rtcp_pkg;

  localparam int unsigned ScreenWidth  = 320;
  localparam int unsigned ScreenHeight = 240;

  localparam int unsigned XW     = 9;
  localparam int unsigned YW     = 8;
  localparam int unsigned LimitW = 10;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [XW-1:0] XMax = XW'(ScreenWidth - 1);
  localparam logic [YW-1:0] YMax = YW'(ScreenHeight - 1);

  localparam logic [LimitW-1:0] HeaderGapReset   = LimitW'(50);
  localparam logic [LimitW-1:0] PayloadTimeReset = LimitW'(200);

  localparam logic [CfgIdxW-1:0] CfgHeaderGap   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPayloadTime = CfgIdxW'(1);

  localparam logic [7:0] HdrFirst   = 8'hAA;
  localparam logic [7:0] HdrSecond  = 8'h55;
  localparam logic [7:0] CmdFrame   = 8'h01;
  localparam logic [7:0] CmdTouch   = 8'h02;
  localparam logic [7:0] CmdRelease = 8'h03;

  typedef enum logic [1:0] {
    EV_FRAME   = 2'd0,
    EV_DOWN    = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_e;

  typedef struct packed {
    event_kind_e   kind;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          pressed;
  } result_t;

endpackage

// ===== hdl/rtcp_if.sv =====
// ----------------------------------------------------------------------------
// Remote touch command parser channels
// Valid/ready channels for input items and for result words.
// ----------------------------------------------------------------------------
interface rtcp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface rtcp_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               event_kind;
  logic [rtcp_pkg::XW-1:0]  touch_x;
  logic [rtcp_pkg::YW-1:0]  touch_y;
  logic                     pressed;

  modport source (output valid, output event_kind, output touch_x, output touch_y,
                  output pressed, input ready);
  modport sink (input valid, input event_kind, input touch_x, input touch_y,
                input pressed, output ready);
endinterface

// ===== hdl/rtcp_parser.sv =====
// ----------------------------------------------------------------------------
// Remote touch command parser core
// Frame state machine, tick timeouts, payload gathering and held touch state.
// ----------------------------------------------------------------------------
module rtcp_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rtcp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtcp_pkg::LimitW-1:0]  cfg_data_i,
  input  logic                         accept_i,
  input  logic                         action_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         res_valid_o,
  output rtcp_pkg::result_t            res_o
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DOWN = 3'd3;
  localparam logic [2:0] PH_UP   = 3'd4;

  logic [rtcp_pkg::LimitW-1:0] gap_lim_q, pay_lim_q;
  logic [2:0]                  phase_q, phase_d;
  logic [rtcp_pkg::LimitW-1:0] elapsed_q, elapsed_d;
  logic [2:0]                  gathered_q, gathered_d;
  logic [7:0]                  store_q [4];
  logic [7:0]                  store_d [4];
  logic [7:0]                  sum_q, sum_d;
  logic                        held_p_q, held_p_d;
  logic [rtcp_pkg::XW-1:0]     held_x_q, held_x_d;
  logic [rtcp_pkg::YW-1:0]     held_y_q, held_y_d;

  logic                        emit;
  rtcp_pkg::event_kind_e       kind;
  logic [rtcp_pkg::LimitW-1:0] lim;
  logic                        expired;
  logic                        finish;
  logic [7:0]                  check;
  logic [15:0]                 x_raw, y_raw;

  always_comb begin
    lim     = (phase_q == PH_HDR2) ? gap_lim_q : pay_lim_q;
    expired = elapsed_q >= lim;
    x_raw   = {store_q[0], store_q[1]};
    y_raw   = {store_q[2], store_q[3]};
  end

  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    gathered_d = gathered_q;
    store_d    = store_q;
    sum_d      = sum_q;
    held_p_d   = held_p_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    emit       = 1'b0;
    kind       = rtcp_pkg::EV_FRAME;
    finish     = 1'b0;
    check      = 8'h00;

    if (action_i) begin
      case (phase_q)
        PH_HDR2, PH_DOWN, PH_UP: begin
          if (!expired) begin
            elapsed_d = elapsed_q + rtcp_pkg::LimitW'(1);
          end else if (phase_q == PH_HDR2) begin
            phase_d = PH_HUNT;
          end else if (phase_q == PH_DOWN) begin
            finish = 1'b1;
          end else begin
            phase_d  = PH_HUNT;
            held_p_d = 1'b0;
            emit     = 1'b1;
            kind     = rtcp_pkg::EV_RELEASE;
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (phase_q)
        PH_HUNT: begin
          if (data_byte_i == rtcp_pkg::HdrFirst) begin
            phase_d   = PH_HDR2;
            elapsed_d = '0;
          end
        end
        PH_HDR2: begin
          phase_d = (data_byte_i == rtcp_pkg::HdrSecond) ? PH_CMD : PH_HUNT;
        end
        PH_CMD: begin
          phase_d = PH_HUNT;
          if (data_byte_i == rtcp_pkg::CmdFrame) begin
            emit = 1'b1;
            kind = rtcp_pkg::EV_FRAME;
          end else if (data_byte_i == rtcp_pkg::CmdTouch) begin
            phase_d    = PH_DOWN;
            elapsed_d  = '0;
            gathered_d = '0;
            store_d    = '{default: 8'h00};
            sum_d      = rtcp_pkg::CmdTouch;
          end else if (data_byte_i == rtcp_pkg::CmdRelease) begin
            phase_d   = PH_UP;
            elapsed_d = '0;
          end
        end
        PH_DOWN: begin
          if (gathered_q < 3'd4) begin
            store_d[gathered_q[1:0]] = data_byte_i;
            sum_d      = sum_q + data_byte_i;
            gathered_d = gathered_q + 3'd1;
          end else begin
            finish = 1'b1;
            check  = data_byte_i;
          end
        end
        PH_UP: begin
          phase_d = PH_HUNT;
          if (data_byte_i == rtcp_pkg::CmdRelease) begin
            held_p_d = 1'b0;
            emit     = 1'b1;
            kind     = rtcp_pkg::EV_RELEASE;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end

    if (finish) begin
      phase_d = PH_HUNT;
      if (sum_q == check) begin
        held_x_d = (x_raw >= 16'(rtcp_pkg::ScreenWidth)) ? rtcp_pkg::XMax
                                                          : x_raw[rtcp_pkg::XW-1:0];
        held_y_d = (y_raw >= 16'(rtcp_pkg::ScreenHeight)) ? rtcp_pkg::YMax
                                                           : y_raw[rtcp_pkg::YW-1:0];
        held_p_d = 1'b1;
        emit     = 1'b1;
        kind     = rtcp_pkg::EV_DOWN;
      end
    end
  end

  assign res_valid_o  = accept_i && emit;
  assign res_o.kind    = kind;
  assign res_o.x       = held_x_d;
  assign res_o.y       = held_y_d;
  assign res_o.pressed = held_p_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_lim_q <= rtcp_pkg::HeaderGapReset;
      pay_lim_q <= rtcp_pkg::PayloadTimeReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rtcp_pkg::CfgHeaderGap) begin
        gap_lim_q <= cfg_data_i;
      end else if (cfg_idx_i == rtcp_pkg::CfgPayloadTime) begin
        pay_lim_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      elapsed_q  <= '0;
      gathered_q <= '0;
      store_q    <= '{default: 8'h00};
      sum_q      <= '0;
      held_p_q   <= 1'b0;
      held_x_q   <= '0;
      held_y_q   <= '0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      gathered_q <= gathered_d;
      store_q    <= store_d;
      sum_q      <= sum_d;
      held_p_q   <= held_p_d;
      held_x_q   <= held_x_d;
      held_y_q   <= held_y_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_down_presses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == rtcp_pkg::EV_DOWN) |-> res_o.pressed)
    else $error("touch down event without pressed");
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.x <= rtcp_pkg::XMax && res_o.y <= rtcp_pkg::YMax))
    else $error("reported coordinate outside the screen");
  a_event_resyncs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> phase_q == PH_HUNT)
    else $error("parser did not return to hunting after an event");
`endif

endmodule

// ===== hdl/rtcp_outq.sv =====
// ----------------------------------------------------------------------------
// Remote touch command parser output queue
// Two-entry result buffer that decouples the parser from the output channel.
// ----------------------------------------------------------------------------
module rtcp_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rtcp_pkg::result_t data_i,
  output logic              full_o,
  rtcp_out_if.source        out
);

  rtcp_pkg::result_t buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign pop            = out.valid && out.ready;
  assign full_o         = count_q == 2'd2;
  assign out.valid      = count_q != 2'd0;
  assign out.event_kind = buf_q[rd_ptr_q].kind;
  assign out.touch_x    = buf_q[rd_ptr_q].x;
  assign out.touch_y    = buf_q[rd_ptr_q].y;
  assign out.pressed    = buf_q[rd_ptr_q].pressed;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/remote_touch_command_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Remote touch command parser
// Frames serial bytes and millisecond ticks into touch and frame events.
// ----------------------------------------------------------------------------
// A result word is registered in the output queue before it leaves on the output channel.
// Throughput: one item per cycle while the result queue is not full; the parser state updates in one pass.
// A two-entry result queue keeps input ready while one word waits to leave.
// Reset returns the parser to hunting, empties the result queue and loads the default limits at once.
module remote_touch_command_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rtcp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rtcp_pkg::LimitW-1:0]  cfg_data_i,
  rtcp_in_if.sink                      in_i,
  rtcp_out_if.source                   out_o
);

  logic              accept;
  logic              full;
  logic              res_valid;
  rtcp_pkg::result_t res;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  rtcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .action_i    (in_i.action),
    .data_byte_i (in_i.data_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rtcp_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .full_o (full),
    .out    (out_o)
  );

endmodule
